>>> sv/bldm_pkg.sv
// ----------------------------------------------------------------------------
// bldm_pkg: shared types and constants of the LED dimmer controller
// Holds the tick item, the result item, the register write record and the
// fixed timing constants of the timed light.
// ----------------------------------------------------------------------------
package bldm_pkg;

  // Ticks in one cycle of the timed light and the gap between the two flashes.
  localparam int unsigned CycleTicks = 255;
  localparam int unsigned FlashGap   = 8;

  localparam logic [7:0] CYCLE_TICKS = 8'(CycleTicks);
  localparam logic [7:0] FLASH_GAP   = 8'(FlashGap);

  // Register indexes on the configuration channel.
  localparam logic [2:0] CFG_START_MODE   = 3'd0;
  localparam logic [2:0] CFG_START_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_LONG_PRESS   = 3'd2;
  localparam logic [2:0] CFG_RAMP_STEP    = 3'd3;
  localparam logic [2:0] CFG_SENSE_PERIOD = 3'd4;
  localparam logic [2:0] CFG_LIT_THR      = 3'd5;
  localparam logic [2:0] CFG_DARK_THR     = 3'd6;
  localparam logic [2:0] CFG_TIMER_CYCLES = 3'd7;

  // Mode codes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_AUTO  = 2'd2;

  typedef struct packed {
    logic [7:0] light_sample;
    logic       button_pressed;
  } bldm_item_t;

  typedef struct packed {
    logic       save_level;
    logic       save_mode;
    logic [7:0] level_now;
    logic [1:0] mode_now;
    logic       indicator_pulse;
    logic [7:0] pwm_duty;
  } bldm_result_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] addr;
    logic [8:0] data;
  } bldm_cfg_wr_t;

endpackage

>>> sv/bldm_core.sv
// ----------------------------------------------------------------------------
// bldm_core: controller state and per-tick update
// Keeps the mode, level, duty, phase and counters, applies register writes
// and works out the next state and the result of one tick in a single pass.
// ----------------------------------------------------------------------------
module bldm_core
  import bldm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  bldm_item_t   item_i,
  input  bldm_cfg_wr_t cfg_i,
  output bldm_result_t result_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PRESS   = 3'd1;
  localparam logic [2:0] PH_RAMP    = 3'd2;
  localparam logic [2:0] PH_HOLD    = 3'd3;
  localparam logic [2:0] PH_RUN     = 3'd4;
  localparam logic [2:0] PH_ENDHOLD = 3'd5;

  // Configuration registers.
  logic [7:0] long_press_q, ramp_step_q, lit_thr_q, dark_thr_q, timer_cycles_q;
  logic [8:0] sense_period_q;

  // Controller state.
  logic [1:0] mode_q, mode_d;
  logic [7:0] bright_q, bright_d;
  logic [7:0] duty_q, duty_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] press_q, press_d;
  logic [8:0] idle_q, idle_d;
  logic [7:0] ramp_q, ramp_d;
  logic       ramp_up_q, ramp_up_d;
  logic [7:0] cyc_cnt_q, cyc_cnt_d;
  logic [7:0] cyc_tick_q, cyc_tick_d;
  logic       entry_save_q;

  // Intermediate results of one tick.
  logic       pulse, save_mode, save_level;
  logic       press_go, step_go, run_go, idle_go, idle_clear, run_fresh;
  logic [7:0] press_base, press_next, step_level;
  logic [7:0] run_tick_base, run_tick_next, run_cnt_base, run_cnt_next;
  logic [8:0] idle_base, idle_next;
  logic [7:0] thr;

  always_comb begin
    mode_d     = mode_q;
    bright_d   = bright_q;
    duty_d     = duty_q;
    phase_d    = phase_q;
    press_d    = press_q;
    idle_d     = idle_q;
    ramp_d     = ramp_q;
    ramp_up_d  = ramp_up_q;
    cyc_cnt_d  = cyc_cnt_q;
    cyc_tick_d = cyc_tick_q;
    pulse      = 1'b0;
    save_mode  = entry_save_q;
    save_level = 1'b0;
    press_go   = 1'b0;
    press_base = press_q;
    step_go    = 1'b0;
    run_go     = 1'b0;
    run_fresh  = 1'b0;
    idle_go    = 1'b0;
    idle_clear = 1'b0;

    unique case (phase_q)
      PH_PRESS: begin
        if (item_i.button_pressed) begin
          press_go = 1'b1;
        end else begin
          mode_d     = (mode_q >= MODE_AUTO) ? MODE_OFF : 2'(mode_q + 2'd1);
          save_mode  = 1'b1;
          idle_go    = 1'b1;
          idle_clear = 1'b1;
        end
      end
      PH_RAMP: begin
        ramp_d = 8'(ramp_q + 8'd1);
        if (ramp_d == ramp_step_q) begin
          ramp_d = '0;
          if (item_i.button_pressed) begin
            step_go = 1'b1;
          end else begin
            ramp_up_d  = ~ramp_up_q;
            save_level = 1'b1;
            idle_go    = 1'b1;
            idle_clear = 1'b1;
          end
        end
      end
      PH_HOLD: begin
        if (!item_i.button_pressed) begin
          phase_d   = PH_RUN;
          run_go    = 1'b1;
          run_fresh = 1'b1;
        end
      end
      PH_RUN: begin
        run_go = 1'b1;
      end
      PH_ENDHOLD: begin
        if (!item_i.button_pressed) begin
          idle_go    = 1'b1;
          idle_clear = 1'b1;
        end
      end
      default: begin
        if (item_i.button_pressed) begin
          phase_d    = PH_PRESS;
          press_go   = 1'b1;
          press_base = '0;
        end else begin
          idle_go = 1'b1;
        end
      end
    endcase

    // Held-button counting; a long press starts the timed light or a ramp.
    press_next = 8'(press_base + 8'd1);
    if (press_go) begin
      press_d = press_next;
      if (press_next == long_press_q) begin
        if (mode_q == MODE_OFF) begin
          duty_d  = bright_q;
          phase_d = PH_HOLD;
        end else begin
          phase_d = PH_RAMP;
          ramp_d  = '0;
          step_go = 1'b1;
        end
      end
    end

    // One ramp step; a pulse marks a level already at its limit.
    step_level = bright_q;
    if (ramp_up_q) begin
      if (bright_q == 8'hFF) pulse = step_go;
      else                   step_level = {bright_q[6:0], 1'b1};
    end else begin
      if (bright_q == 8'd1) pulse = step_go;
      else                  step_level = {1'b0, bright_q[7:1]};
    end
    if (step_go) begin
      bright_d = step_level;
      duty_d   = step_level;
    end

    // Timed light: two flashes at the start of every cycle.
    run_tick_base = run_fresh ? 8'd0 : cyc_tick_q;
    run_cnt_base  = run_fresh ? 8'd0 : cyc_cnt_q;
    run_tick_next = 8'(run_tick_base + 8'd1);
    run_cnt_next  = 8'(run_cnt_base + 8'd1);
    if (run_go) begin
      if (item_i.button_pressed) begin
        duty_d  = '0;
        phase_d = PH_ENDHOLD;
      end else begin
        if (run_tick_base == 8'd0 || run_tick_base == FLASH_GAP) pulse = 1'b1;
        cyc_tick_d = run_tick_next;
        cyc_cnt_d  = run_cnt_base;
        if (run_tick_next == CYCLE_TICKS) begin
          cyc_tick_d = '0;
          cyc_cnt_d  = run_cnt_next;
          if (run_cnt_next == timer_cycles_q) begin
            duty_d  = '0;
            phase_d = PH_IDLE;
            idle_d  = '0;
          end
        end
      end
    end

    // Released idling: the mode action repeats once per sense period.
    idle_base = idle_clear ? 9'd0 : idle_q;
    idle_next = 9'(idle_base + 9'd1);
    thr       = (duty_q != 8'd0) ? lit_thr_q : dark_thr_q;
    if (idle_go) begin
      phase_d = PH_IDLE;
      if (idle_base == 9'd0) begin
        if (mode_d == MODE_FIXED) begin
          duty_d = bright_q;
        end else if (mode_d == MODE_AUTO) begin
          duty_d = (item_i.light_sample > thr) ? bright_q : 8'd0;
          pulse  = 1'b1;
        end else begin
          duty_d = '0;
        end
      end
      idle_d = (idle_next == sense_period_q) ? 9'd0 : idle_next;
    end
  end

  always_comb begin
    result_o.pwm_duty        = duty_d;
    result_o.indicator_pulse = pulse;
    result_o.mode_now        = mode_d;
    result_o.level_now       = bright_d;
    result_o.save_mode       = save_mode;
    result_o.save_level      = save_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= 8'd255;
      ramp_step_q    <= 8'd40;
      sense_period_q <= 9'd256;
      lit_thr_q      <= 8'd64;
      dark_thr_q     <= 8'd128;
      timer_cycles_q <= 8'd255;
      mode_q         <= MODE_OFF;
      bright_q       <= 8'd255;
      duty_q         <= '0;
      phase_q        <= PH_IDLE;
      press_q        <= '0;
      idle_q         <= '0;
      ramp_q         <= '0;
      ramp_up_q      <= 1'b0;
      cyc_cnt_q      <= '0;
      cyc_tick_q     <= '0;
      entry_save_q   <= 1'b1;
    end else begin
      if (step_i) begin
        mode_q       <= mode_d;
        bright_q     <= bright_d;
        duty_q       <= duty_d;
        phase_q      <= phase_d;
        press_q      <= press_d;
        idle_q       <= idle_d;
        ramp_q       <= ramp_d;
        ramp_up_q    <= ramp_up_d;
        cyc_cnt_q    <= cyc_cnt_d;
        cyc_tick_q   <= cyc_tick_d;
        entry_save_q <= 1'b0;
      end
      // The user must write only while no tick is in flight; the block does not enforce this, and a write simply wins.
      if (cfg_i.valid) begin
        unique case (cfg_i.addr)
          CFG_START_MODE: begin
            mode_q       <= (cfg_i.data[1:0] == 2'd3) ? MODE_OFF : cfg_i.data[1:0];
            entry_save_q <= 1'b1;
          end
          CFG_START_LEVEL:  bright_q       <= cfg_i.data[7:0];
          CFG_LONG_PRESS:   long_press_q   <= cfg_i.data[7:0];
          CFG_RAMP_STEP:    ramp_step_q    <= cfg_i.data[7:0];
          CFG_SENSE_PERIOD: sense_period_q <= cfg_i.data;
          CFG_LIT_THR:      lit_thr_q      <= cfg_i.data[7:0];
          CFG_DARK_THR:     dark_thr_q     <= cfg_i.data[7:0];
          CFG_TIMER_CYCLES: timer_cycles_q <= cfg_i.data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/button_led_dimmer_mode_controller.sv
// ----------------------------------------------------------------------------
// button_led_dimmer_mode_controller: three-mode LED dimmer driven by ticks
// Input register, single-pass tick update and output register.
// ----------------------------------------------------------------------------
// Usage
//   Each transfer on the s_ channel is one 5 ms tick with the button level
//   and a light-sensor sample. Each tick yields exactly one transfer on the
//   m_ channel with the duty, indicator pulse, mode, level and save flags.
//   Registers are written on the cfg_ channel, which is always ready; write
//   only while no tick is in flight.
// Pipeline and throughput
//   A taken tick passes the input register, then its result is held in the
//   output register. One tick per cycle is sustained while m_tready_i is high,
//   set by the combinational state update between the registers.
// Reset
//   rst_ni clears both stages, loads the register defaults, and the first
//   result after reset carries save_mode.
// Stalls
//   While m_tready_i is low the result holds; one more tick waits in the
//   input register, after which s_tready_o drops.
// ----------------------------------------------------------------------------
module button_led_dimmer_mode_controller
  import bldm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [0] button_pressed, [8:1] light_sample, [15:9] zero
  input  logic [15:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] pwm_duty, [8] indicator_pulse, [10:9] mode_now, [18:11] level_now,
  // [19] save_mode, [20] save_level, [23:21] zero
  output logic [23:0] m_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [8:0]  cfg_data_i
);

  logic         in_valid_q;
  bldm_item_t   in_item_q;
  logic         out_valid_q;
  bldm_result_t out_q, step_res;
  logic         advance;
  bldm_cfg_wr_t cfg_wr;

  assign advance     = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_wr.valid = cfg_valid_i;
    cfg_wr.addr  = cfg_addr_i;
    cfg_wr.data  = cfg_data_i;
  end

  bldm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg_wr),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) in_valid_q <= s_tvalid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_item_q.button_pressed <= s_tdata_i[0];
      in_item_q.light_sample   <= s_tdata_i[8:1];
    end
    if (advance) out_q <= step_res;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, out_q.save_level, out_q.save_mode, out_q.level_now,
                       out_q.mode_now, out_q.indicator_pulse, out_q.pwm_duty};

endmodule

>>> sv/bldm_checker.sv
// ----------------------------------------------------------------------------
// bldm_checker: port-level checks of the LED dimmer controller
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module bldm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [23:0] m_tdata_i
);

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed or vanished while stalled");

  // The mode field never shows the unused code.
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[10:9] != 2'b11)
    else $error("mode_now carries an unused code");

  // Every tick taken is followed by a result on offer from the output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |-> ##2 m_tvalid_i)
    else $error("no result two cycles after a tick transfer");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[23:21] == 3'b000)
    else $error("result padding is not zero");

endmodule

bind button_led_dimmer_mode_controller bldm_checker u_bldm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o)
);

>>> tb/sv/dimmer_checker.sv
// ----------------------------------------------------------------------------
// dimmer_checker: output predictor and comparator for the LED dimmer
// Watches the tick, result and register channels. Every accepted tick is run
// through a local model of the mode, level and timer behavior, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dimmer_checker
  import bldm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [8:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESS,
    PH_RAMP,
    PH_HOLD,
    PH_RUN,
    PH_ENDHOLD
  } tick_phase_e;

  // Register copies.
  logic [1:0] start_mode_r;
  logic [7:0] start_level_r;
  logic [7:0] long_press_r;
  logic [7:0] ramp_step_r;
  logic [8:0] sense_period_r;
  logic [7:0] lit_thr_r;
  logic [7:0] dark_thr_r;
  logic [7:0] timer_cycles_r;

  // Controller state.
  logic [1:0]  mode_q;
  logic [7:0]  level_q;
  logic [7:0]  duty_q;
  tick_phase_e phase_q;
  logic [7:0]  press_cnt;
  logic [8:0]  idle_cnt;
  logic [7:0]  ramp_cnt;
  logic        ramp_up;
  logic [7:0]  cycle_cnt;
  logic [7:0]  cycle_tick;
  logic        entry_save;
  logic        pulse;

  bldm_result_t predicted_outputs[$];
  int unsigned  fail_count;
  int unsigned  outstanding;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  function automatic logic [1:0] clip_mode(input logic [1:0] m);
    return (m > MODE_AUTO) ? MODE_OFF : m;
  endfunction

  // Released tick: the mode action runs whenever the sense counter is at zero.
  function automatic void idle_released(input logic [7:0] sample);
    phase_q = PH_IDLE;
    if (idle_cnt == 9'd0) begin
      case (mode_q)
        MODE_FIXED: duty_q = level_q;
        MODE_AUTO: begin
          duty_q = (sample > ((duty_q != 8'd0) ? lit_thr_r : dark_thr_r)) ? level_q : 8'd0;
          pulse = 1'b1;
        end
        default: duty_q = 8'd0;
      endcase
    end
    idle_cnt = idle_cnt + 9'd1;
    if (idle_cnt == sense_period_r) idle_cnt = 9'd0;
  endfunction

  function automatic void ramp_step();
    if (ramp_up) begin
      if (level_q == 8'hFF) pulse = 1'b1;
      else level_q = {level_q[6:0], 1'b1};
    end else begin
      if (level_q == 8'd1) pulse = 1'b1;
      else level_q = level_q >> 1;
    end
    duty_q = level_q;
  endfunction

  function automatic void count_press();
    press_cnt = press_cnt + 8'd1;
    if (press_cnt == long_press_r) begin
      if (mode_q == MODE_OFF) begin
        duty_q  = level_q;
        phase_q = PH_HOLD;
      end else begin
        phase_q  = PH_RAMP;
        ramp_cnt = 8'd0;
        ramp_step();
      end
    end
  endfunction

  function automatic void run_tick(input logic pressed);
    if (pressed) begin
      duty_q  = 8'd0;
      phase_q = PH_ENDHOLD;
    end else begin
      if (cycle_tick == 8'd0 || cycle_tick == FLASH_GAP) pulse = 1'b1;
      cycle_tick = cycle_tick + 8'd1;
      if (cycle_tick == CYCLE_TICKS) begin
        cycle_tick = 8'd0;
        cycle_cnt  = cycle_cnt + 8'd1;
        if (cycle_cnt == timer_cycles_r) begin
          duty_q   = 8'd0;
          phase_q  = PH_IDLE;
          idle_cnt = 9'd0;
        end
      end
    end
  endfunction

  function automatic bldm_result_t advance_tick(input logic pressed, input logic [7:0] sample);
    bldm_result_t r;
    logic         save_mode;
    logic         save_level;
    pulse      = 1'b0;
    save_mode  = entry_save;
    save_level = 1'b0;
    entry_save = 1'b0;
    case (phase_q)
      PH_PRESS: begin
        if (pressed) begin
          count_press();
        end else begin
          // Short press: advance the mode and act on it in the same tick.
          mode_q    = (mode_q >= MODE_AUTO) ? MODE_OFF : mode_q + 2'd1;
          save_mode = 1'b1;
          idle_cnt  = 9'd0;
          idle_released(sample);
        end
      end
      PH_RAMP: begin
        ramp_cnt = ramp_cnt + 8'd1;
        // The button is only looked at on step boundaries.
        if (ramp_cnt == ramp_step_r) begin
          ramp_cnt = 8'd0;
          if (pressed) begin
            ramp_step();
          end else begin
            ramp_up    = ~ramp_up;
            save_level = 1'b1;
            idle_cnt   = 9'd0;
            idle_released(sample);
          end
        end
      end
      PH_HOLD: begin
        if (!pressed) begin
          phase_q    = PH_RUN;
          cycle_cnt  = 8'd0;
          cycle_tick = 8'd0;
          run_tick(1'b0);
        end
      end
      PH_RUN: run_tick(pressed);
      PH_ENDHOLD: begin
        if (!pressed) begin
          idle_cnt = 9'd0;
          idle_released(sample);
        end
      end
      default: begin
        if (pressed) begin
          phase_q   = PH_PRESS;
          press_cnt = 8'd0;
          count_press();
        end else begin
          idle_released(sample);
        end
      end
    endcase
    r.pwm_duty        = duty_q;
    r.indicator_pulse = pulse;
    r.mode_now        = mode_q;
    r.level_now       = level_q;
    r.save_mode       = save_mode;
    r.save_level      = save_level;
    return r;
  endfunction

  function automatic void write_register(input logic [2:0] addr, input logic [8:0] data);
    case (addr)
      CFG_START_MODE: begin
        start_mode_r = data[1:0];
        mode_q       = clip_mode(data[1:0]);
        entry_save   = 1'b1;
      end
      CFG_START_LEVEL: begin
        start_level_r = data[7:0];
        level_q       = data[7:0];
      end
      CFG_LONG_PRESS:   long_press_r   = data[7:0];
      CFG_RAMP_STEP:    ramp_step_r    = data[7:0];
      CFG_SENSE_PERIOD: sense_period_r = data;
      CFG_LIT_THR:      lit_thr_r      = data[7:0];
      CFG_DARK_THR:     dark_thr_r     = data[7:0];
      CFG_TIMER_CYCLES: timer_cycles_r = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic string fmt_result(input bldm_result_t r);
    return $sformatf("duty=%0d pulse=%0b mode=%0d level=%0d save_mode=%0b save_level=%0b",
                     r.pwm_duty, r.indicator_pulse, r.mode_now, r.level_now,
                     r.save_mode, r.save_level);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bldm_result_t want;
    bldm_result_t seen;
    if (!rst_ni) begin
      start_mode_r   = MODE_OFF;
      start_level_r  = 8'd255;
      long_press_r   = 8'd255;
      ramp_step_r    = 8'd40;
      sense_period_r = 9'd256;
      lit_thr_r      = 8'd64;
      dark_thr_r     = 8'd128;
      timer_cycles_r = 8'd255;
      mode_q         = clip_mode(start_mode_r);
      level_q        = start_level_r;
      duty_q         = 8'd0;
      phase_q        = PH_IDLE;
      press_cnt      = 8'd0;
      idle_cnt       = 9'd0;
      ramp_cnt       = 8'd0;
      ramp_up        = 1'b0;
      cycle_cnt      = 8'd0;
      cycle_tick     = 8'd0;
      entry_save     = 1'b1;
      pulse          = 1'b0;
      predicted_outputs.delete();
      outstanding    = 0;
    end else begin
      // Results are retired before new ticks are queued so that a stray
      // result can never consume a prediction made in the same cycle.
      if (m_tvalid_i && m_tready_i) begin
        seen = bldm_result_t'(m_tdata_i[20:0]);
        if (predicted_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result with nothing expected: %s", $realtime, fmt_result(seen));
        end else begin
          want = predicted_outputs.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] result mismatch\n  expected %s\n  actual   %s",
                       $realtime, fmt_result(want), fmt_result(seen));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_addr_i, cfg_data_i);
      if (s_tvalid_i && s_tready_i)
        predicted_outputs.push_back(advance_tick(s_tdata_i[0], s_tdata_i[8:1]));
      outstanding = predicted_outputs.size();
    end
  end

  initial fail_count = 0;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LED dimmer controller
// Drives button gestures and sensor samples through the tick channel under
// several register settings and flow-control profiles, while a checker
// instance predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import bldm_pkg::*;
();

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr  = '0;
  logic [8:0]  cfg_data  = '0;

  int unsigned fail_count;
  int unsigned outstanding;

  // Flow-control profile, in percent.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // Effective timing of the current setting, used to shape gestures.
  int unsigned long_press_len = 255;
  int unsigned ramp_len       = 40;
  int unsigned sense_len      = 256;
  logic [7:0]  lit_level      = 8'd64;
  logic [7:0]  dark_level     = 8'd128;

  int unsigned ticks_sent = 0;

  button_led_dimmer_mode_controller uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  dimmer_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'hFF;
      2:       return lit_level + 8'($urandom_range(1));
      3:       return dark_level + 8'($urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic set_pressure(input int unsigned profile);
    case (profile)
      1:       begin src_idle_pct = 47; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 47; end
      3:       begin src_idle_pct = 22; sink_stall_pct = 22; end
      default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_tick(input logic pressed, input logic [7:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, sample, pressed};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  // A negative sample picks a fresh random sample for every tick.
  task automatic hold(input logic pressed, input int unsigned n, input int sample);
    repeat (n) send_tick(pressed, (sample < 0) ? pick_sample() : 8'(sample));
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= 9'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned mode, input int unsigned level,
                           input int unsigned long_press, input int unsigned ramp,
                           input int unsigned sense, input int unsigned lit,
                           input int unsigned dark, input int unsigned cycles);
    write_reg(CFG_START_MODE, mode);
    write_reg(CFG_START_LEVEL, level);
    write_reg(CFG_LONG_PRESS, long_press);
    write_reg(CFG_RAMP_STEP, ramp);
    write_reg(CFG_SENSE_PERIOD, sense);
    write_reg(CFG_LIT_THR, lit);
    write_reg(CFG_DARK_THR, dark);
    write_reg(CFG_TIMER_CYCLES, cycles);
    // A zero count stands for the full range of its counter.
    long_press_len = (long_press == 0) ? 256 : long_press;
    ramp_len       = (ramp == 0) ? 256 : ramp;
    sense_len      = (sense == 0) ? 512 : sense;
    lit_level      = 8'(lit);
    dark_level     = 8'(dark);
  endtask

  // Mostly well-formed button gestures, each followed by a released stretch.
  task automatic play_gestures(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30 && long_press_len > 1)
        hold(1'b1, $urandom_range(1, long_press_len - 1), -1);
      else if (pick < 60)
        hold(1'b1, long_press_len + $urandom_range(0, 3 * ramp_len), -1);
      else if (pick < 70)
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), pick_sample());
      // Now and then the release outlasts CycleTicks ticks, so a timed light set to a single timer cycle can finish.
      if ($urandom_range(19) == 0) hold(1'b0, 300, -1);
      else hold(1'b0, $urandom_range(1, 30), -1);
    end
  endtask

  task automatic run_setting(input int unsigned profile, input int unsigned budget);
    set_pressure(profile);
    // Start with a released stretch that wraps the sense counter at least once.
    hold(1'b0, (sense_len + 2 > 600) ? 600 : sense_len + 2, -1);
    play_gestures(budget);
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: every mode, both presses, timed light and a ramp.
    configure(MODE_OFF, 255, 2, 1, 3, 64, 128, 1);
    hold(1'b0, 2, 0);
    hold(1'b1, 1, 255);
    hold(1'b0, 1, 255);
    hold(1'b1, 1, 0);
    hold(1'b0, 2, 255);
    hold(1'b0, 1, 0);
    hold(1'b1, 1, 0);
    hold(1'b0, 1, 0);
    hold(1'b1, 2, 0);
    hold(1'b0, 9, 0);
    hold(1'b1, 1, 0);
    hold(1'b0, 1, 0);
    hold(1'b1, 1, 0);
    hold(1'b0, 1, 0);
    hold(1'b1, 4, 255);
    hold(1'b0, 1, 255);
    settle();

    // Start mode three, level zero, one-tick long press and shortest periods.
    configure(3, 0, 1, 1, 1, 0, 255, 1);
    run_setting(1, 100);
    configure(MODE_FIXED, 255, 3, 2, 5, 64, 128, 2);
    run_setting(2, 100);
    // Zero sense period and zero timer cycles, extreme thresholds.
    configure(MODE_AUTO, 1, 5, 3, 0, 255, 0, 0);
    run_setting(3, 100);
    // Zero long press and ramp step counts.
    configure(MODE_OFF, 15, 0, 0, 256, 100, 200, 255);
    run_setting(0, 100);
    for (int i = 1; i <= 3; i++) begin
      configure($urandom_range(3), $urandom_range(255), $urandom_range(1, 8),
                $urandom_range(1, 4), $urandom_range(1, 20), $urandom_range(255),
                $urandom_range(255), $urandom_range(1, 2));
      run_setting(i, 80);
    end

    if (fail_count == 0 && outstanding == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
